### rtl/rhhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rhhm_pkg;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_ITER   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_FULL       = 3'd2,
		ST_ITER_END   = 3'd3,
		ST_BAD_CURSOR = 3'd4
	} status_t;

	typedef struct packed {
		req_t        req_type;
		logic [63:0] key;
		logic [63:0] key_digest;
		logic [63:0] new_value;
		logic [7:0]  cursor;
	} req_item_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] found_key;
		logic [63:0] found_value;
		logic [7:0]  next_cursor;
		logic [7:0]  live_count;
	} rsp_item_t;

endpackage

`default_nettype wire

### rtl/rhhm_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rhhm_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/robin_hood_ordered_hash_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Payload    | Transfers when
// req     | in        | req_item_t | req.valid && req.ready
// rsp     | out       | rsp_item_t | rsp.valid && rsp.ready
//
// Every request transaction gives exactly one response transaction.
// After reset a clearing pass writes every bucket empty, and req.ready stays low
// until it ends.
// A lookup or insert visits buckets in probe order and compares keys; each bucket
// and entry read goes through a registered memory read before it is evaluated.
// An insert that displaces an occupant then walks on to place it.
// A remove then moves back each bucket of the probe run. Compaction copies the
// live entries to the front, clears the index, then rebuilds it by probing for each
// live entry.
// The response sits in an output register, so a stalled rsp channel holds one finished
// transaction while the next request is already accepted and worked on.

module robin_hood_ordered_hash_map #(
	parameter int INDEX_SLOTS = 256,
	parameter int ENTRY_SLOTS = 192,
	parameter int KEY_BITS    = 64,
	parameter int VALUE_BITS  = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	rhhm_chan_if.sink    req,
	rhhm_chan_if.source  rsp
);
	import rhhm_pkg::*;

	localparam int IW        = $clog2(INDEX_SLOTS);
	localparam int PW        = $clog2(ENTRY_SLOTS);
	localparam int CW        = $clog2(ENTRY_SLOTS + 1);
	localparam int DW        = IW + 2;
	localparam int NW        = IW + 1;
	localparam int BW        = 1 + PW + IW;
	localparam int EW        = 1 + 64 + VALUE_BITS + KEY_BITS;
	localparam int CMPW      = (CW > 8) ? CW : 8;
	localparam int FULL_LIVE = 3 * (ENTRY_SLOTS / 4);

	typedef enum logic [17:0] {
		S_IDLE  = 18'(1) << 0,
		S_CLR   = 18'(1) << 1,
		S_PB_RD = 18'(1) << 2,
		S_PB_EV = 18'(1) << 3,
		S_PE_RD = 18'(1) << 4,
		S_PE_EV = 18'(1) << 5,
		S_UL_RD = 18'(1) << 6,
		S_UL_EV = 18'(1) << 7,
		S_POST  = 18'(1) << 8,
		S_CP_RD = 18'(1) << 9,
		S_CP_EV = 18'(1) << 10,
		S_RB_RD = 18'(1) << 11,
		S_RB_EV = 18'(1) << 12,
		S_PL_RD = 18'(1) << 13,
		S_PL_EV = 18'(1) << 14,
		S_IT_RD = 18'(1) << 15,
		S_IT_EV = 18'(1) << 16,
		S_DONE  = 18'(1) << 17
	} state_t;

	// Bucket word: used flag, entry position, and the ideal bucket of that entry
	// kept alongside so that a probe step needs no entry read to get displacement.
	logic [BW-1:0] bk_mem [INDEX_SLOTS];
	logic [EW-1:0] ent_mem [ENTRY_SLOTS];
	logic [BW-1:0] bk_rd_q;
	logic [EW-1:0] ent_rd_q;

	logic          bk_we;
	logic [IW-1:0] bk_wa;
	logic [BW-1:0] bk_wd;
	logic          ent_we;
	logic [PW-1:0] ent_wa;
	logic [EW-1:0] ent_wd;
	logic [PW-1:0] ent_ra;

	state_t                state_q, state_d;
	req_t                  op_q, op_d;
	logic [KEY_BITS-1:0]   k_q, k_d;
	logic [63:0]           h_q, h_d;
	logic [VALUE_BITS-1:0] v_q, v_d;
	logic [IW-1:0]         b_q, b_d;
	logic [DW-1:0]         d_q, d_d;
	logic [NW-1:0]         n_q, n_d;
	logic [PW-1:0]         pos_q, pos_d;
	logic [IW-1:0]         chlo_q, chlo_d;
	logic [IW-1:0]         hole_q, hole_d;
	logic [CW-1:0]         app_q, app_d;
	logic [CW-1:0]         live_q, live_d;
	logic [CW-1:0]         r_q, r_d;
	logic [CW-1:0]         w_q, w_d;
	logic [IW-1:0]         clr_q, clr_d;
	logic                  rb_q, rb_d;
	logic                  full_q, full_d;
	rsp_item_t             res_q, res_d;
	rsp_item_t             out_q, out_d;
	logic                  out_v_q, out_v_d;

	logic                  bk_used;
	logic [PW-1:0]         bk_pos;
	logic [IW-1:0]         bk_hlo;
	logic [IW-1:0]         od;
	logic                  e_dead;
	logic [63:0]           e_hash;
	logic [VALUE_BITS-1:0] e_val;
	logic [KEY_BITS-1:0]   e_key;
	logic                  find_mode;

	assign bk_used = bk_rd_q[BW-1];
	assign bk_pos  = bk_rd_q[PW+IW-1:IW];
	assign bk_hlo  = bk_rd_q[IW-1:0];
	assign od      = b_q - bk_hlo;
	assign e_key   = ent_rd_q[KEY_BITS-1:0];
	assign e_val   = ent_rd_q[KEY_BITS+VALUE_BITS-1:KEY_BITS];
	assign e_hash  = ent_rd_q[KEY_BITS+VALUE_BITS+63:KEY_BITS+VALUE_BITS];
	assign e_dead  = ent_rd_q[EW-1];

	// Lookups, removes and inserts into a full store only search; a normal insert
	// takes over the first bucket that is empty or whose occupant is closer to home.
	assign find_mode = (op_q != REQ_INSERT) || full_q;

	assign ent_ra    = (state_q == S_PE_RD) ? pos_q : PW'(r_q);
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk) begin
		if (bk_we) begin
			bk_mem[bk_wa] <= bk_wd;
		end
		bk_rd_q <= bk_mem[b_q];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		ent_rd_q <= ent_mem[ent_ra];
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		k_d     = k_q;
		h_d     = h_q;
		v_d     = v_q;
		b_d     = b_q;
		d_d     = d_q;
		n_d     = n_q;
		pos_d   = pos_q;
		chlo_d  = chlo_q;
		hole_d  = hole_q;
		app_d   = app_q;
		live_d  = live_q;
		r_d     = r_q;
		w_d     = w_q;
		clr_d   = clr_q;
		rb_d    = rb_q;
		full_d  = full_q;
		res_d   = res_q;
		out_d   = out_q;
		out_v_d = out_v_q && !rsp.ready;
		bk_we   = 1'b0;
		bk_wa   = b_q;
		bk_wd   = '0;
		ent_we  = 1'b0;
		ent_wa  = pos_q;
		ent_wd  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d              = req.data.req_type;
					k_d               = req.data.key[KEY_BITS-1:0];
					h_d               = req.data.key_digest;
					v_d               = req.data.new_value[VALUE_BITS-1:0];
					b_d               = req.data.key_digest[IW-1:0];
					d_d               = '0;
					full_d            = 1'b0;
					res_d.status      = ST_OK;
					res_d.found_key   = '0;
					res_d.found_value = '0;
					res_d.next_cursor = '0;
					res_d.live_count  = '0;
					unique case (req.data.req_type)
						REQ_LOOKUP, REQ_REMOVE: begin
							if (live_q == '0) begin
								res_d.status = ST_NOT_FOUND;
								state_d      = S_DONE;
							end else begin
								state_d = S_PB_RD;
							end
						end
						REQ_INSERT: begin
							if (app_q >= CW'(ENTRY_SLOTS)) begin
								if (live_q >= CW'(FULL_LIVE)) begin
									full_d  = 1'b1;
									state_d = S_PB_RD;
								end else if (app_q != live_q) begin
									r_d     = '0;
									w_d     = '0;
									state_d = S_CP_RD;
								end else begin
									res_d.status = ST_FULL;
									state_d      = S_DONE;
								end
							end else begin
								state_d = S_PB_RD;
							end
						end
						REQ_ITER: begin
							if (CMPW'(req.data.cursor) > CMPW'(app_q)) begin
								res_d.status = ST_BAD_CURSOR;
								state_d      = S_DONE;
							end else begin
								r_d     = CW'(req.data.cursor);
								state_d = S_IT_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end

			S_CLR: begin
				bk_we = 1'b1;
				bk_wa = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == IW'(INDEX_SLOTS - 1)) begin
					r_d     = '0;
					state_d = rb_q ? S_RB_RD : S_IDLE;
				end
			end

			S_PB_RD: state_d = S_PB_EV;

			S_PB_EV: begin
				if (d_q == DW'(INDEX_SLOTS) || !bk_used || (DW'(od) < d_q && find_mode)) begin
					res_d.status = (op_q == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
					state_d      = S_DONE;
				end else if (DW'(od) < d_q || !bk_used) begin
					// Unreachable in find mode; kept as the normal insert branch below.
					state_d = S_DONE;
				end else begin
					pos_d   = bk_pos;
					state_d = S_PE_RD;
				end
				// A normal insert claims an empty bucket or evicts a closer-to-home occupant.
				if (!find_mode && d_q != DW'(INDEX_SLOTS) && (!bk_used || DW'(od) < d_q)) begin
					bk_we             = 1'b1;
					bk_wd             = {1'b1, PW'(app_q), h_q[IW-1:0]};
					ent_we            = 1'b1;
					ent_wa            = PW'(app_q);
					ent_wd            = {1'b0, h_q, v_q, k_q};
					app_d             = app_q + 1'b1;
					live_d            = live_q + 1'b1;
					res_d.status      = ST_OK;
					res_d.found_key   = 64'(k_q);
					res_d.found_value = 64'(v_q);
					if (bk_used) begin
						pos_d   = bk_pos;
						chlo_d  = bk_hlo;
						b_d     = b_q + 1'b1;
						d_d     = DW'(od) + 1'b1;
						n_d     = '0;
						state_d = S_PL_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end

			S_PE_RD: state_d = S_PE_EV;

			S_PE_EV: begin
				if (e_hash == h_q && e_key == k_q) begin
					case (op_q)
						REQ_INSERT: begin
							ent_we            = 1'b1;
							ent_wd            = {e_dead, e_hash, v_q, e_key};
							res_d.found_key   = 64'(k_q);
							res_d.found_value = 64'(v_q);
							state_d           = S_DONE;
						end
						REQ_REMOVE: begin
							res_d.found_key   = 64'(e_key);
							res_d.found_value = 64'(e_val);
							live_d            = live_q - 1'b1;
							if (CW'(pos_q) + 1'b1 == app_q) begin
								app_d = app_q - 1'b1;
							end else begin
								ent_we = 1'b1;
								ent_wd = {1'b1, e_hash, e_val, e_key};
							end
							if (live_q == CW'(1)) begin
								app_d = '0;
							end
							hole_d  = b_q;
							b_d     = b_q + 1'b1;
							n_d     = '0;
							state_d = S_UL_RD;
						end
						default: begin
							res_d.found_key   = 64'(e_key);
							res_d.found_value = 64'(e_val);
							state_d           = S_DONE;
						end
					endcase
				end else begin
					b_d     = b_q + 1'b1;
					d_d     = d_q + 1'b1;
					state_d = S_PB_RD;
				end
			end

			S_UL_RD: state_d = S_UL_EV;

			// Backward shift: each occupant that is away from home moves one bucket back,
			// and the last hole is written empty when the run ends.
			S_UL_EV: begin
				bk_we = 1'b1;
				bk_wa = hole_q;
				if (n_q == NW'(INDEX_SLOTS) || !bk_used || od == '0) begin
					bk_wd   = '0;
					state_d = S_POST;
				end else begin
					bk_wd   = bk_rd_q;
					hole_d  = b_q;
					b_d     = b_q + 1'b1;
					n_d     = n_q + 1'b1;
					state_d = S_UL_RD;
				end
			end

			S_POST: begin
				if (live_q <= (app_q >> 1) && app_q != live_q) begin
					r_d     = '0;
					w_d     = '0;
					state_d = S_CP_RD;
				end else begin
					state_d = S_DONE;
				end
			end

			S_CP_RD: state_d = S_CP_EV;

			S_CP_EV: begin
				if (!e_dead) begin
					ent_we = 1'b1;
					ent_wa = PW'(w_q);
					ent_wd = ent_rd_q;
					w_d    = w_q + 1'b1;
				end
				if (r_q + 1'b1 == app_q) begin
					app_d   = w_d;
					live_d  = w_d;
					clr_d   = '0;
					rb_d    = 1'b1;
					state_d = S_CLR;
				end else begin
					r_d     = r_q + 1'b1;
					state_d = S_CP_RD;
				end
			end

			S_RB_RD: begin
				if (r_q == app_q) begin
					rb_d = 1'b0;
					if (op_q == REQ_INSERT) begin
						if (app_q >= CW'(ENTRY_SLOTS)) begin
							res_d.status = ST_FULL;
							state_d      = S_DONE;
						end else begin
							b_d     = h_q[IW-1:0];
							d_d     = '0;
							full_d  = 1'b0;
							state_d = S_PB_RD;
						end
					end else begin
						state_d = S_DONE;
					end
				end else begin
					state_d = S_RB_EV;
				end
			end

			S_RB_EV: begin
				pos_d   = PW'(r_q);
				chlo_d  = e_hash[IW-1:0];
				b_d     = e_hash[IW-1:0];
				d_d     = '0;
				n_d     = '0;
				r_d     = r_q + 1'b1;
				state_d = S_PL_RD;
			end

			S_PL_RD: state_d = S_PL_EV;

			S_PL_EV: begin
				if (n_q == NW'(INDEX_SLOTS) || !bk_used) begin
					if (n_q != NW'(INDEX_SLOTS)) begin
						bk_we = 1'b1;
						bk_wd = {1'b1, pos_q, chlo_q};
					end
					state_d = rb_q ? S_RB_RD : S_DONE;
				end else begin
					if (DW'(od) < d_q) begin
						bk_we  = 1'b1;
						bk_wd  = {1'b1, pos_q, chlo_q};
						pos_d  = bk_pos;
						chlo_d = bk_hlo;
						d_d    = DW'(od) + 1'b1;
					end else begin
						d_d = d_q + 1'b1;
					end
					b_d     = b_q + 1'b1;
					n_d     = n_q + 1'b1;
					state_d = S_PL_RD;
				end
			end

			S_IT_RD: begin
				if (r_q >= app_q) begin
					res_d.status      = ST_ITER_END;
					res_d.next_cursor = 8'(app_q);
					state_d           = S_DONE;
				end else begin
					state_d = S_IT_EV;
				end
			end

			S_IT_EV: begin
				if (!e_dead) begin
					res_d.status      = ST_OK;
					res_d.found_key   = 64'(e_key);
					res_d.found_value = 64'(e_val);
					res_d.next_cursor = 8'(r_q + 1'b1);
					state_d           = S_DONE;
				end else begin
					r_d     = r_q + 1'b1;
					state_d = S_IT_RD;
				end
			end

			S_DONE: begin
				if (!out_v_q || rsp.ready) begin
					out_d            = res_q;
					out_d.live_count = 8'(live_q);
					out_v_d          = 1'b1;
					state_d          = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			app_q   <= '0;
			live_q  <= '0;
			clr_q   <= '0;
			rb_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			app_q   <= app_d;
			live_q  <= live_d;
			clr_q   <= clr_d;
			rb_q    <= rb_d;
			out_v_q <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		k_q    <= k_d;
		h_q    <= h_d;
		v_q    <= v_d;
		b_q    <= b_d;
		d_q    <= d_d;
		n_q    <= n_d;
		pos_q  <= pos_d;
		chlo_q <= chlo_d;
		hole_q <= hole_d;
		r_q    <= r_d;
		w_q    <= w_d;
		full_q <= full_d;
		res_q  <= res_d;
		out_q  <= out_d;
	end

	a_live_le_app: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= app_q)
		else $error("live count exceeds appended length");

	a_app_bound: assert property (@(posedge clk) disable iff (!arst_n)
		app_q <= CW'(ENTRY_SLOTS))
		else $error("appended length beyond store size");

	a_empty_store: assert property (@(posedge clk) disable iff (!arst_n)
		live_q == '0 |-> app_q == '0)
		else $error("store not emptied with no live entries");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!out_v_q || rsp.ready) |=> state_q == S_IDLE && out_v_q)
		else $error("response not handed to output register");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

import rhhm_pkg::*;

module tb_top;

	localparam int BUCKETS      = 256;
	localparam int SLOTS        = 192;
	localparam int RANDOM_ITEMS = 830;
	// No transaction for this many cycles means the block is stuck. The limit leaves
	// room for a worst-case compaction with long probe runs on rebuild and for the
	// monitor's ready stalls.
	localparam int STALL_LIMIT  = 400000;

	logic clk;
	logic arst_n;

	rhhm_chan_if #(.payload_t(req_item_t)) req_ch ();
	rhhm_chan_if #(.payload_t(rsp_item_t)) rsp_ch ();

	robin_hood_ordered_hash_map i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the map: bucket index plus insertion-ordered entry store.
	logic [7:0]  idx_pos  [BUCKETS];
	logic        idx_used [BUCKETS];
	logic [63:0] ent_key  [SLOTS];
	logic [63:0] ent_val  [SLOTS];
	logic [63:0] ent_hash [SLOTS];
	logic        ent_dead [SLOTS];
	int          fill_len;
	int          live_cnt;

	req_item_t pending_reqs[$];
	rsp_item_t expected_rsps[$];

	int mismatches;
	int quiet_cycles;
	bit stim_done;

	// Probe distance of the entry held at a bucket from its home bucket.
	function automatic int probe_dist(int pos, int b);
		return (b - int'(ent_hash[pos][7:0])) & (BUCKETS - 1);
	endfunction

	function automatic bit map_find(logic [63:0] k, logic [63:0] h, output int bkt,
			output int pos);
		int b;
		int d;
		b = int'(h[7:0]);
		d = 0;
		bkt = 0;
		pos = 0;
		if (live_cnt == 0) return 0;
		for (int n = 0; n < BUCKETS; n++) begin
			if (!idx_used[b]) return 0;
			if (d > probe_dist(idx_pos[b], b)) return 0;
			if (ent_hash[idx_pos[b]] == h && ent_key[idx_pos[b]] == k) begin
				bkt = b;
				pos = int'(idx_pos[b]);
				return 1;
			end
			b = (b + 1) & (BUCKETS - 1);
			d++;
		end
		return 0;
	endfunction

	// Robin Hood placement without a key check, used on rebuild and displacement.
	function automatic void rh_place(int pos, int b, int d);
		int od;
		int t;
		for (int n = 0; n < BUCKETS; n++) begin
			b &= BUCKETS - 1;
			if (!idx_used[b]) begin
				idx_used[b] = 1'b1;
				idx_pos[b] = 8'(pos);
				return;
			end
			od = probe_dist(idx_pos[b], b);
			if (od < d) begin
				t = int'(idx_pos[b]);
				idx_pos[b] = 8'(pos);
				pos = t;
				d = od;
			end
			b++;
			d++;
		end
	endfunction

	// Squeeze out dead entries in order, then rebuild the index.
	function automatic void squeeze_store();
		int w;
		w = 0;
		if (fill_len == live_cnt) return;
		for (int r = 0; r < fill_len; r++) begin
			if (!ent_dead[r]) begin
				ent_key[w] = ent_key[r];
				ent_val[w] = ent_val[r];
				ent_hash[w] = ent_hash[r];
				ent_dead[w] = 1'b0;
				w++;
			end
		end
		fill_len = w;
		live_cnt = w;
		for (int i = 0; i < BUCKETS; i++) idx_used[i] = 1'b0;
		for (int i = 0; i < w; i++) rh_place(i, int'(ent_hash[i][7:0]), 0);
	endfunction

	// Remove a bucket and shift the rest of its probe run back by one.
	function automatic void unlink_and_shift(int hole);
		int cur;
		cur = (hole + 1) & (BUCKETS - 1);
		idx_used[hole] = 1'b0;
		for (int n = 0; n < BUCKETS; n++) begin
			if (!idx_used[cur]) return;
			if (probe_dist(idx_pos[cur], cur) == 0) return;
			idx_pos[hole] = idx_pos[cur];
			idx_used[hole] = 1'b1;
			idx_used[cur] = 1'b0;
			hole = cur;
			cur = (cur + 1) & (BUCKETS - 1);
		end
	endfunction

	function automatic void append_entry(logic [63:0] k, logic [63:0] h, logic [63:0] v);
		ent_key[fill_len] = k;
		ent_val[fill_len] = v;
		ent_hash[fill_len] = h;
		ent_dead[fill_len] = 1'b0;
		fill_len++;
		live_cnt++;
	endfunction

	function automatic status_t map_insert(logic [63:0] k, logic [63:0] h, logic [63:0] v);
		int b;
		int d;
		int p;
		int od;
		int fb;
		int fp;
		if (fill_len >= SLOTS) begin
			if ((live_cnt / 3) >= (SLOTS / 4)) begin
				if (map_find(k, h, fb, fp)) begin
					ent_val[fp] = v;
					return ST_OK;
				end
				return ST_FULL;
			end
			squeeze_store();
			if (fill_len >= SLOTS) return ST_FULL;
		end
		b = int'(h[7:0]);
		d = 0;
		for (int n = 0; n < BUCKETS; n++) begin
			if (!idx_used[b]) begin
				idx_used[b] = 1'b1;
				idx_pos[b] = 8'(fill_len);
				append_entry(k, h, v);
				return ST_OK;
			end
			p = int'(idx_pos[b]);
			od = probe_dist(p, b);
			if (od < d) begin
				idx_pos[b] = 8'(fill_len);
				append_entry(k, h, v);
				rh_place(p, (b + 1) & (BUCKETS - 1), od + 1);
				return ST_OK;
			end
			if (ent_hash[p] == h && ent_key[p] == k) begin
				ent_val[p] = v;
				return ST_OK;
			end
			b = (b + 1) & (BUCKETS - 1);
			d++;
		end
		return ST_FULL;
	endfunction

	// Apply one request to the shadow map and return the response it must produce.
	function automatic rsp_item_t map_apply(req_item_t r);
		rsp_item_t e;
		int b;
		int p;
		e = '0;
		e.status = ST_OK;
		case (r.req_type)
			REQ_LOOKUP: begin
				if (map_find(r.key, r.key_digest, b, p)) begin
					e.found_key = ent_key[p];
					e.found_value = ent_val[p];
				end else begin
					e.status = ST_NOT_FOUND;
				end
			end
			REQ_INSERT: begin
				e.status = map_insert(r.key, r.key_digest, r.new_value);
				if (e.status == ST_OK) begin
					e.found_key = r.key;
					e.found_value = r.new_value;
				end
			end
			REQ_REMOVE: begin
				if (map_find(r.key, r.key_digest, b, p)) begin
					e.found_key = ent_key[p];
					e.found_value = ent_val[p];
					if (p + 1 == fill_len) fill_len--;
					else ent_dead[p] = 1'b1;
					live_cnt--;
					if (live_cnt == 0) fill_len = 0;
					unlink_and_shift(b);
					if (live_cnt <= fill_len / 2) squeeze_store();
				end else begin
					e.status = ST_NOT_FOUND;
				end
			end
			default: begin
				if (int'(r.cursor) > fill_len) begin
					e.status = ST_BAD_CURSOR;
				end else begin
					e.status = ST_ITER_END;
					e.next_cursor = 8'(fill_len);
					for (int i = int'(r.cursor); i < fill_len; i++) begin
						if (!ent_dead[i]) begin
							e.status = ST_OK;
							e.found_key = ent_key[i];
							e.found_value = ent_val[i];
							e.next_cursor = 8'(i + 1);
							break;
						end
					end
				end
			end
		endcase
		e.live_count = 8'(live_cnt);
		return e;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic req_item_t make_req(req_t t, logic [63:0] k, logic [63:0] h,
			logic [63:0] v, logic [7:0] c);
		req_item_t r;
		r.req_type = t;
		r.key = k;
		r.key_digest = h;
		r.new_value = v;
		r.cursor = c;
		return r;
	endfunction

	// Random requests draw keys from a small pool so that lookups and removes hit.
	// Hashes are derived from the key with only a few home buckets, which forces
	// long probe runs, displacement and backward shifts.
	logic [63:0] key_pool [64];

	function automatic logic [63:0] hash_of(int i);
		return {key_pool[i][63:8] ^ 56'h5a5a_0f0f_3c3c_99, 8'(i * 37 % 29)};
	endfunction

	function automatic req_item_t random_req(int pool_n);
		int i;
		int sel;
		req_t t;
		i = $urandom_range(pool_n - 1);
		sel = $urandom_range(99);
		if (sel < 45) t = REQ_INSERT;
		else if (sel < 70) t = REQ_REMOVE;
		else if (sel < 85) t = REQ_LOOKUP;
		else t = REQ_ITER;
		if ($urandom_range(19) == 0) begin
			// Noise: a pool key with a random hash, value and cursor.
			return make_req(t, key_pool[i], rand64(), rand64(), 8'($urandom()));
		end
		return make_req(t, key_pool[i], hash_of(i), rand64(), 8'($urandom_range(200)));
	endfunction

	initial begin
		int pool_n;
		arst_n = 1'b0;
		clk = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		mismatches = 0;
		stim_done = 1'b0;
		fill_len = 0;
		live_cnt = 0;
		for (int i = 0; i < BUCKETS; i++) begin
			idx_used[i] = 1'b0;
			idx_pos[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			ent_key[i] = '0;
			ent_val[i] = '0;
			ent_hash[i] = '0;
			ent_dead[i] = 1'b0;
		end
		for (int i = 0; i < 64; i++) key_pool[i] = rand64();
		key_pool[0] = '0;
		key_pool[1] = '1;

		// Directed part: empty map, extremes of every field, every request type,
		// overwrite of an existing key, bad cursor, iteration end and emptying.
		pending_reqs.push_back(make_req(REQ_LOOKUP, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(REQ_REMOVE, '1, '1, '1, '1));
		pending_reqs.push_back(make_req(REQ_ITER, '0, '0, '0, 8'd0));
		pending_reqs.push_back(make_req(REQ_INSERT, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(REQ_INSERT, '1, '1, '1, '1));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'h1, 64'h0, 64'h7, '0));
		pending_reqs.push_back(make_req(REQ_INSERT, '1, '1, 64'h5555, '0));
		pending_reqs.push_back(make_req(REQ_LOOKUP, '1, '1, '0, '0));
		pending_reqs.push_back(make_req(REQ_LOOKUP, '1, 64'hfe, '0, '0));
		pending_reqs.push_back(make_req(REQ_ITER, '0, '0, '0, 8'd0));
		pending_reqs.push_back(make_req(REQ_ITER, '0, '0, '0, 8'd3));
		pending_reqs.push_back(make_req(REQ_ITER, '0, '0, '0, 8'd4));
		pending_reqs.push_back(make_req(REQ_ITER, '0, '0, '0, 8'hff));
		pending_reqs.push_back(make_req(REQ_REMOVE, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(REQ_ITER, '0, '0, '0, 8'd0));
		pending_reqs.push_back(make_req(REQ_REMOVE, 64'h1, 64'h0, '0, '0));
		pending_reqs.push_back(make_req(REQ_REMOVE, '1, '1, '0, '0));
		pending_reqs.push_back(make_req(REQ_LOOKUP, '1, '1, '0, '0));
		// Fill the store past its size to reach the full status, then remove and refill to reach compaction.
		for (int i = 0; i < 200; i++)
			pending_reqs.push_back(make_req(REQ_INSERT, 64'(i + 100), 64'(i * 3), rand64(), '0));
		pending_reqs.push_back(make_req(REQ_INSERT, 64'd100, 64'd0, '1, '0));
		for (int i = 0; i < 150; i++)
			pending_reqs.push_back(make_req(REQ_REMOVE, 64'(i + 100), 64'(i * 3), '0, '0));
		for (int i = 0; i < 60; i++)
			pending_reqs.push_back(make_req(REQ_INSERT, 64'(i + 1000), rand64(), rand64(), '0));
		for (int i = 0; i < 42; i++)
			pending_reqs.push_back(make_req(REQ_REMOVE, 64'(i + 250), 64'((i + 150) * 3),
					'0, '0));

		// Random part, in phases with a key pool that alternates between 16 and 64 keys so the map fills and drains.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pool_n = (n / 200) % 2 == 0 ? 16 : 64;
			pending_reqs.push_back(random_req(pool_n));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: holds valid until a transaction is accepted, then waits a random gap before the next.
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_left <= 0;
		end else if (req_ch.valid && !req_ch.ready) begin
			// Hold the transaction.
		end else if (gap_left > 0) begin
			req_ch.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_reqs.size() > 0) begin
			req_ch.data <= pending_reqs[0];
			req_ch.valid <= 1'b1;
			expected_rsps.push_back(map_apply(pending_reqs.pop_front()));
			// Runs without gaps show up when the first draw lands in the low third or the second draws zero.
			gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(9);
		end else begin
			req_ch.valid <= 1'b0;
			stim_done <= 1'b1;
		end
	end

	// Monitor: random ready stalls and a field-by-field compare against the oldest
	// expectation.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t e;
		rsp_item_t a;
		int wait_n;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				a = rsp_ch.data;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected response transaction: %p", a);
				end else begin
					e = expected_rsps.pop_front();
					if (a.status !== e.status || a.found_key !== e.found_key ||
							a.found_value !== e.found_value ||
							a.next_cursor !== e.next_cursor ||
							a.live_count !== e.live_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Response mismatch: expected %p, got %p", e, a);
					end
				end
				// Ready goes low for a randomly drawn stall, or stays high when the draw is zero.
				wait_n = ($urandom_range(2) == 0) ? 0 : $urandom_range(9);
				stall_left <= (wait_n > 0) ? wait_n - 1 : 0;
				rsp_ch.ready <= (wait_n == 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog and end of run.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		quiet_cycles = 0;
		wait (arst_n);
		fork
			begin
				wait (stim_done && expected_rsps.size() == 0);
				repeat (200) @(posedge clk);
			end
			wait (quiet_cycles >= STALL_LIMIT);
		join_any
		if (quiet_cycles < STALL_LIMIT && expected_rsps.size() == 0 && mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
rtl/rhhm_pkg.sv
rtl/rhhm_chan_if.sv
rtl/robin_hood_ordered_hash_map.sv
tb/sv/tb_top.sv
